[design/time_varying_complex_fir_unit_assert.svh]
// assertion macros used by the filter top level
`ifndef TIME_VARYING_COMPLEX_FIR_UNIT_ASSERT_SVH
`define TIME_VARYING_COMPLEX_FIR_UNIT_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the cycle after the trigger
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tvcf_pkg.sv]
// shared constants and types of the time-varying complex fir filter
package tvcf_pkg;

  localparam int MAX_TAPS_DEF     = 32;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int MAX_DELAY_DEF    = 63;

  localparam int ACC_W      = 40;
  localparam int COEF_W     = 16;
  localparam int OUT_W      = 16;
  localparam int TAP_IDX_W  = 5;
  localparam int CNT_W      = 16;
  localparam int PAD_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES = 2'd2;

  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [PAD_W-1:0] pad_n;
    logic             emit;
    logic [OUT_W-1:0] re;
    logic [OUT_W-1:0] im;
  } q_entry_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
  } q_status_t;

endpackage

[design/tvcf_ram.sv]
// generic single-write, single-read ram with registered read data
module tvcf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/tvcf_out_queue.sv]
// result queue that expands padding beats and drives the output register
module tvcf_out_queue import tvcf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  q_entry_t                push_data,
  output q_status_t               status,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_re,
  output logic signed [OUT_W-1:0] out_im,
  output logic                    is_padding,
  output logic                    last
);

  q_entry_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QCNT_W-1:0] count;
  logic [PAD_W-1:0]  pad_sent;

  q_entry_t          head;
  logic              load;
  logic              beat_pad;
  logic              beat_final;
  logic              pop;

  assign head       = mem[rd_ptr];
  assign load       = (count != '0) && (!out_valid || out_ready);
  assign beat_pad   = pad_sent != head.pad_n;
  assign beat_final = beat_pad ? ((pad_sent + PAD_W'(1) == head.pad_n) && !head.emit) : 1'b1;
  assign pop        = load && beat_final;

  assign status.count = count;
  assign status.full  = count == QCNT_W'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (load) begin
      out_re     <= beat_pad ? '0 : head.re;
      out_im     <= beat_pad ? '0 : head.im;
      is_padding <= beat_pad;
      last       <= beat_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      count     <= '0;
      pad_sent  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr   <= rd_ptr + QPTR_W'(1);
        pad_sent <= '0;
      end else if (load) begin
        pad_sent <= pad_sent + PAD_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[design/time_varying_complex_fir_unit.sv]
// Time-varying complex fir filter top level. One tap coefficient is taken per cycle while
// in_ready is high, so a sample with N active taps is fed as N tap items. The input pauses
// only while results back up in the eight-entry result queue, which happens when the output
// stalls or while the frame-start item sends out its delay_samples padding beats, one per
// cycle while out_ready is high. Samples live in a circular buffer ram of MAX_TAPS entries;
// taps older than the frame start read as zero, so no clearing pass exists.
`include "time_varying_complex_fir_unit_assert.svh"

module time_varying_complex_fir_unit import tvcf_pkg::*; #(
  parameter int MAX_TAPS     = MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int MAX_DELAY    = MAX_DELAY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     frame_start,
  input  logic [TAP_IDX_W-1:0]     tap_index,
  input  logic signed [COEF_W-1:0] coef_re,
  input  logic signed [COEF_W-1:0] coef_im,
  input  logic signed [15:0]       sample_re,
  input  logic signed [15:0]       sample_im,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [OUT_W-1:0]  out_re,
  output logic signed [OUT_W-1:0]  out_im,
  output logic                     is_padding,
  output logic                     last
);

  localparam int PTR_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CALC_W = PTR_W + 6;
  localparam int TC_W   = ($clog2(MAX_TAPS + 1) > 6) ? $clog2(MAX_TAPS + 1) : 6;
  localparam int SW     = SAMPLE_WIDTH;
  localparam int PROD_W = COEF_W + SW;
  localparam int TERM_W = PROD_W + 1;
  localparam int SUM_W  = ((TERM_W > ACC_W) ? TERM_W : ACC_W) + 1;
  localparam int Q_W    = ACC_W - 14;

  // configuration
  logic [5:0]  tap_count;
  logic [15:0] frame_length;
  logic [5:0]  delay_samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count     <= 6'd1;
      frame_length  <= 16'hFFFF;
      delay_samples <= 6'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAP_COUNT:     tap_count     <= cfg_data[5:0];
        REG_FRAME_LENGTH:  frame_length  <= cfg_data;
        REG_DELAY_SAMPLES: delay_samples <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // input decode
  logic [PTR_W-1:0]     head;
  logic [CNT_W-1:0]     sample_count;
  logic                 accept;
  logic                 is_t0;
  logic                 fs_eff;
  logic [TC_W-1:0]      tc_ext;
  logic [TC_W-1:0]      taps_eff;
  logic [5:0]           delay_eff;
  logic [CNT_W-1:0]     count_base;
  logic [CNT_W-1:0]     count_next;
  logic [PTR_W-1:0]     head_next;
  logic [CALC_W-1:0]    h_ext;
  logic [CALC_W-1:0]    t_ext;
  logic [CALC_W-1:0]    rd_diff;
  logic                 tap_ok;
  logic                 emit;
  logic [PAD_W-1:0]     pad_n;
  logic [SW+15:0]       sre_wide;
  logic [SW+15:0]       sim_wide;
  logic signed [SW-1:0] s_re;
  logic signed [SW-1:0] s_im;
  logic [2*SW-1:0]      ram_rdata;

  assign accept   = in_valid && in_ready;
  assign is_t0    = tap_index == '0;
  assign fs_eff   = frame_start && is_t0;
  assign tc_ext   = TC_W'(tap_count);
  assign taps_eff = (tap_count == '0) ? TC_W'(1) :
                    ((tc_ext > TC_W'(MAX_TAPS)) ? TC_W'(MAX_TAPS) : tc_ext);
  assign delay_eff = (delay_samples > 6'(MAX_DELAY)) ? 6'(MAX_DELAY) : delay_samples;

  assign count_base = fs_eff ? '0 : sample_count;
  assign count_next = !is_t0 ? sample_count :
                      ((count_base == '1) ? count_base : count_base + CNT_W'(1));
  assign head_next  = !is_t0 ? head :
                      ((head == PTR_W'(MAX_TAPS - 1)) ? '0 : head + PTR_W'(1));

  assign h_ext   = CALC_W'(head_next);
  assign t_ext   = CALC_W'(tap_index);
  assign rd_diff = (h_ext >= t_ext) ? h_ext - t_ext : h_ext + CALC_W'(MAX_TAPS) - t_ext;

  assign tap_ok = (TC_W'(tap_index) < taps_eff) && (CNT_W'(tap_index) < count_next);
  assign emit   = (TC_W'(tap_index) == taps_eff - TC_W'(1)) && (count_next != '0) &&
                  ((17'(count_next) + 17'(delay_eff)) <= 17'(frame_length));
  assign pad_n  = !fs_eff ? '0 :
                  ((16'(delay_eff) < frame_length) ? delay_eff : frame_length[PAD_W-1:0]);

  assign sre_wide = {{SW{1'b0}}, sample_re};
  assign sim_wide = {{SW{1'b0}}, sample_im};
  assign s_re     = sre_wide[SW-1:0];
  assign s_im     = sim_wide[SW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      sample_count <= '0;
    end else if (accept) begin
      head         <= head_next;
      sample_count <= count_next;
    end
  end

  tvcf_ram #(
    .WIDTH (2 * SW),
    .DEPTH (MAX_TAPS)
  ) u_line (
    .clk   (clk),
    .we    (accept && is_t0),
    .waddr (head_next),
    .wdata ({s_im, s_re}),
    .re    (accept),
    .raddr (rd_diff[PTR_W-1:0]),
    .rdata (ram_rdata)
  );

  // stage 1: sample select
  logic                     p1_valid;
  logic signed [COEF_W-1:0] p1_coef_re;
  logic signed [COEF_W-1:0] p1_coef_im;
  logic signed [SW-1:0]     p1_byp_re;
  logic signed [SW-1:0]     p1_byp_im;
  logic                     p1_use_byp;
  logic                     p1_tap_ok;
  logic                     p1_clear;
  logic                     p1_emit;
  logic [PAD_W-1:0]         p1_pad_n;
  logic signed [SW-1:0]     x_re;
  logic signed [SW-1:0]     x_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    p1_coef_re <= coef_re;
    p1_coef_im <= coef_im;
    p1_byp_re  <= s_re;
    p1_byp_im  <= s_im;
    p1_use_byp <= is_t0;
    p1_tap_ok  <= tap_ok;
    p1_clear   <= is_t0;
    p1_emit    <= emit;
    p1_pad_n   <= pad_n;
  end

  assign x_re = p1_use_byp ? p1_byp_re : $signed(ram_rdata[SW-1:0]);
  assign x_im = p1_use_byp ? p1_byp_im : $signed(ram_rdata[2*SW-1:SW]);

  // stage 2: partial products
  logic                     p2_valid;
  logic signed [PROD_W-1:0] p2_rr;
  logic signed [PROD_W-1:0] p2_ii;
  logic signed [PROD_W-1:0] p2_ri;
  logic signed [PROD_W-1:0] p2_ir;
  logic                     p2_tap_ok;
  logic                     p2_clear;
  logic                     p2_emit;
  logic [PAD_W-1:0]         p2_pad_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p2_rr     <= p1_coef_re * x_re;
    p2_ii     <= p1_coef_im * x_im;
    p2_ri     <= p1_coef_re * x_im;
    p2_ir     <= p1_coef_im * x_re;
    p2_tap_ok <= p1_tap_ok;
    p2_clear  <= p1_clear;
    p2_emit   <= p1_emit;
    p2_pad_n  <= p1_pad_n;
  end

  // stage 3: complex term
  logic                     p3_valid;
  logic signed [TERM_W-1:0] p3_term_re;
  logic signed [TERM_W-1:0] p3_term_im;
  logic                     p3_clear;
  logic                     p3_emit;
  logic [PAD_W-1:0]         p3_pad_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else begin
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    p3_term_re <= p2_tap_ok ? TERM_W'(p2_rr) - TERM_W'(p2_ii) : '0;
    p3_term_im <= p2_tap_ok ? TERM_W'(p2_ri) + TERM_W'(p2_ir) : '0;
    p3_clear   <= p2_clear;
    p3_emit    <= p2_emit;
    p3_pad_n   <= p2_pad_n;
  end

  // stage 4: saturating accumulate
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] s);
    logic signed [ACC_W-1:0] r;
    if ((&s[SUM_W-1:ACC_W-1]) || !(|s[SUM_W-1:ACC_W-1])) begin
      r = s[ACC_W-1:0];
    end else begin
      r = s[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] round_out(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0]   r;
    logic signed [Q_W-1:0]   q;
    logic signed [SW-1:0]    c;
    logic signed [SW+15:0]   w;
    r = (ACC_W+1)'(a) + (ACC_W+1)'(1 << 14);
    q = r[ACC_W:15];
    if ((&q[Q_W-1:SW-1]) || !(|q[Q_W-1:SW-1])) begin
      c = q[SW-1:0];
    end else begin
      c = q[Q_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
    w = (SW+16)'(c);
    return w[OUT_W-1:0];
  endfunction

  logic signed [ACC_W-1:0] acc_re;
  logic signed [ACC_W-1:0] acc_im;
  logic signed [ACC_W-1:0] acc_base_re;
  logic signed [ACC_W-1:0] acc_base_im;
  logic signed [SUM_W-1:0] sum_re;
  logic signed [SUM_W-1:0] sum_im;
  logic                    p4_valid;
  logic                    p4_emit;
  logic [PAD_W-1:0]        p4_pad_n;

  assign acc_base_re = p3_clear ? '0 : acc_re;
  assign acc_base_im = p3_clear ? '0 : acc_im;
  assign sum_re      = SUM_W'(acc_base_re) + SUM_W'(p3_term_re);
  assign sum_im      = SUM_W'(acc_base_im) + SUM_W'(p3_term_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_re   <= '0;
      acc_im   <= '0;
      p4_valid <= 1'b0;
    end else begin
      p4_valid <= p3_valid;
      if (p3_valid) begin
        acc_re <= sat_acc(sum_re);
        acc_im <= sat_acc(sum_im);
      end
    end
  end

  always_ff @(posedge clk) begin
    p4_emit  <= p3_emit;
    p4_pad_n <= p3_pad_n;
  end

  // result queue with credit for items still in the pipe
  q_entry_t  push_data;
  q_status_t q_status;
  logic      push;
  logic      prod1;
  logic      prod2;
  logic      prod3;
  logic      prod4;
  logic [2:0] inflight;

  assign prod1    = p1_valid && (p1_emit || (p1_pad_n != '0));
  assign prod2    = p2_valid && (p2_emit || (p2_pad_n != '0));
  assign prod3    = p3_valid && (p3_emit || (p3_pad_n != '0));
  assign prod4    = p4_valid && (p4_emit || (p4_pad_n != '0));
  assign push     = prod4;
  assign inflight = 3'(prod1) + 3'(prod2) + 3'(prod3) + 3'(prod4);
  assign in_ready = ((QCNT_W+1)'(q_status.count) + (QCNT_W+1)'(inflight)) <
                    (QCNT_W+1)'(QUEUE_DEPTH);

  assign push_data.pad_n = p4_pad_n;
  assign push_data.emit  = p4_emit;
  assign push_data.re    = round_out(acc_re);
  assign push_data.im    = round_out(acc_im);

  tvcf_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .status     (q_status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_re     (out_re),
    .out_im     (out_im),
    .is_padding (is_padding),
    .last       (last)
  );

  `ASSERT_IMPLIES(a_push_has_room, push, !q_status.full, "result queue overflow")
  `ASSERT_IMPLIES(a_pad_is_zero, out_valid && is_padding, (out_re == '0) && (out_im == '0),
                  "padding beat carries data")
  `ASSERT_NEXT(a_head_holds, in_valid && in_ready && (tap_index != '0), $stable(head),
               "sample pointer moved on a non-zero tap")

endmodule
